// File: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
  localparam logic [3:0]  DATA_BITS       = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_S_SDA_UP = 4'd1,
    PH_S_SCL_UP = 4'd2,
    PH_S_SDA_DN = 4'd3,
    PH_S_SCL_DN = 4'd4,
    PH_BIT_LOW  = 4'd5,
    PH_BIT_HIGH = 4'd6,
    PH_P_LOW    = 4'd7,
    PH_P_SCL_UP = 4'd8,
    PH_P_SDA_UP = 4'd9
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ack_bit;
  } result_t;

endpackage

// File: rtl/i2cm_fifo.sv
// Small register FIFO used for the command queue and the result buffer.
module i2cm_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/i2cm_front.sv
// Front end: accepts input items, decodes the command code and queues them.
module i2cm_front #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      func,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            scl_in,
  input  logic            sda_in,
  input  logic            pop,
  output logic            item_valid,
  output i2cm_pkg::item_t item
);

  i2cm_pkg::item_t  wr_item;
  i2cm_pkg::cmd_t   cmd;
  logic             full;
  logic             empty;
  logic [$bits(i2cm_pkg::item_t)-1:0] rd_bits;

  always_comb begin
    case (func)
      i2cm_pkg::CMD_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::CMD_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::CMD_READ:  cmd = i2cm_pkg::CMD_READ;
      i2cm_pkg::CMD_STOP:  cmd = i2cm_pkg::CMD_STOP;
      default:             cmd = i2cm_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    wr_item.cmd       = cmd;
    wr_item.data_byte = data_byte;
    wr_item.last_byte = last_byte;
    wr_item.scl_in    = scl_in;
    wr_item.sda_in    = sda_in;
  end

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid),
    .wr_data (wr_item),
    .pop     (pop),
    .rd_data (rd_bits),
    .full    (full),
    .empty   (empty)
  );

  assign in_ready   = !full;
  assign item_valid = !empty;
  assign item       = i2cm_pkg::item_t'(rd_bits);

endmodule

// File: rtl/i2cm_engine.sv
// Back end: I2C bus phase sequencer, one bus clock cycle per queued item.
module i2cm_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  input  i2cm_pkg::item_t   item,
  input  logic              res_ready,
  output logic              item_pop,
  output logic              res_valid,
  output i2cm_pkg::result_t res
);

  logic [15:0]      half_period;
  i2cm_pkg::phase_t phase, phase_next;
  i2cm_pkg::cmd_t   command, command_next;
  logic [3:0]       bit_count, bit_count_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic             nack_after_read, nack_after_read_next;
  logic [15:0]      half_timer, half_timer_next;
  logic             scl_drive, scl_drive_next;
  logic             sda_drive, sda_drive_next;
  logic             ack_store, ack_store_next;
  logic             done;
  logic             rxv;
  logic [7:0]       rxb;
  logic [15:0]      reload;
  logic             high_phase;
  logic             step;
  logic [3:0]       bc_inc;
  logic [7:0]       shifted;

  assign step     = item_valid && res_ready;
  assign item_pop = step;
  assign res_valid = step;
  assign reload   = (half_period == 16'd0) ? 16'd1 : half_period;
  assign high_phase = (phase == i2cm_pkg::PH_S_SCL_UP) || (phase == i2cm_pkg::PH_BIT_HIGH) ||
                      (phase == i2cm_pkg::PH_P_SCL_UP);
  assign bc_inc   = bit_count + 4'd1;
  assign shifted  = (command == i2cm_pkg::CMD_READ) ? {shift_reg[6:0], item.sda_in}
                                                    : {shift_reg[6:0], 1'b0};

  always_comb begin
    phase_next           = phase;
    command_next         = command;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    nack_after_read_next = nack_after_read;
    half_timer_next      = half_timer;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    ack_store_next       = ack_store;
    done                 = 1'b0;
    rxv                  = 1'b0;
    rxb                  = 8'd0;
    if (phase == i2cm_pkg::PH_IDLE) begin
      command_next = item.cmd;
      case (item.cmd)
        i2cm_pkg::CMD_START: begin
          sda_drive_next  = 1'b1;
          phase_next      = i2cm_pkg::PH_S_SDA_UP;
          half_timer_next = reload;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_reg_next  = item.data_byte;
          bit_count_next  = 4'd0;
          scl_drive_next  = 1'b0;
          sda_drive_next  = item.data_byte[7];
          phase_next      = i2cm_pkg::PH_BIT_LOW;
          half_timer_next = reload;
        end
        i2cm_pkg::CMD_READ: begin
          shift_reg_next       = 8'd0;
          bit_count_next       = 4'd0;
          nack_after_read_next = item.last_byte;
          scl_drive_next       = 1'b0;
          sda_drive_next       = 1'b1;
          phase_next           = i2cm_pkg::PH_BIT_LOW;
          half_timer_next      = reload;
        end
        i2cm_pkg::CMD_STOP: begin
          scl_drive_next  = 1'b0;
          sda_drive_next  = 1'b0;
          phase_next      = i2cm_pkg::PH_P_LOW;
          half_timer_next = reload;
        end
        default: begin
          command_next = i2cm_pkg::CMD_NONE;
        end
      endcase
    end else if (high_phase && !item.scl_in) begin
      // hold while the target stretches SCL
    end else if (half_timer > 16'd1) begin
      half_timer_next = half_timer - 16'd1;
    end else begin
      case (phase)
        i2cm_pkg::PH_S_SDA_UP: begin
          scl_drive_next  = 1'b1;
          phase_next      = i2cm_pkg::PH_S_SCL_UP;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_S_SCL_UP: begin
          sda_drive_next  = 1'b0;
          phase_next      = i2cm_pkg::PH_S_SDA_DN;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_S_SDA_DN: begin
          scl_drive_next  = 1'b0;
          phase_next      = i2cm_pkg::PH_S_SCL_DN;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_S_SCL_DN: begin
          phase_next      = i2cm_pkg::PH_IDLE;
          half_timer_next = 16'd0;
          done            = 1'b1;
        end
        i2cm_pkg::PH_BIT_LOW: begin
          scl_drive_next  = 1'b1;
          phase_next      = i2cm_pkg::PH_BIT_HIGH;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_BIT_HIGH: begin
          if (bit_count < i2cm_pkg::DATA_BITS) begin
            shift_reg_next = shifted;
          end else if (command == i2cm_pkg::CMD_WRITE) begin
            ack_store_next = item.sda_in;
          end
          bit_count_next = bc_inc;
          scl_drive_next = 1'b0;
          if (bc_inc > i2cm_pkg::DATA_BITS) begin
            phase_next      = i2cm_pkg::PH_IDLE;
            half_timer_next = 16'd0;
            done            = 1'b1;
            if (command == i2cm_pkg::CMD_READ) begin
              rxv = 1'b1;
              rxb = shift_reg;
            end
          end else begin
            if (bc_inc == i2cm_pkg::DATA_BITS) begin
              sda_drive_next = (command == i2cm_pkg::CMD_READ) ? nack_after_read : 1'b1;
            end else begin
              sda_drive_next = (command == i2cm_pkg::CMD_READ) ? 1'b1 : shifted[7];
            end
            phase_next      = i2cm_pkg::PH_BIT_LOW;
            half_timer_next = reload;
          end
        end
        i2cm_pkg::PH_P_LOW: begin
          scl_drive_next  = 1'b1;
          phase_next      = i2cm_pkg::PH_P_SCL_UP;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_P_SCL_UP: begin
          sda_drive_next  = 1'b1;
          phase_next      = i2cm_pkg::PH_P_SDA_UP;
          half_timer_next = reload;
        end
        i2cm_pkg::PH_P_SDA_UP: begin
          phase_next      = i2cm_pkg::PH_IDLE;
          half_timer_next = 16'd0;
          done            = 1'b1;
        end
        default: begin
          phase_next      = i2cm_pkg::PH_IDLE;
          half_timer_next = 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_out   = scl_drive_next;
    res.sda_out   = sda_drive_next;
    res.ready_res = (phase_next == i2cm_pkg::PH_IDLE);
    res.cmd_done  = done;
    res.rx_byte   = rxb;
    res.rx_valid  = rxv;
    res.ack_bit   = ack_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cm_pkg::PH_IDLE;
      command         <= i2cm_pkg::CMD_NONE;
      bit_count       <= 4'd0;
      shift_reg       <= 8'd0;
      nack_after_read <= 1'b0;
      half_timer      <= 16'd0;
      scl_drive       <= 1'b1;
      sda_drive       <= 1'b1;
      ack_store       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      command         <= command_next;
      bit_count       <= bit_count_next;
      shift_reg       <= shift_reg_next;
      nack_after_read <= nack_after_read_next;
      half_timer      <= half_timer_next;
      scl_drive       <= scl_drive_next;
      sda_drive       <= sda_drive_next;
      ack_store       <= ack_store_next;
    end
  end

endmodule

// File: rtl/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: command queue, bus sequencer, result buffer.
//
//  channel  | direction | handshake            | payload
//  s_*      | in        | s_tvalid / s_tready  | one sampled bus cycle with optional command
//  m_*      | out       | m_tvalid / m_tready  | line drives and status after that cycle
//  cfg_*    | in        | cfg_valid / cfg_ready| half_period register
//
// One item per clock while the result buffer has room; item and result are both buffered.
// The sequencer advances once per queued item, when the result buffer has room.
// Reset clears the queues and puts both lines released, phase idle, half_period 250.
// Either side may stall; the queues absorb short stalls.
module i2c_master_byte_engine_core #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], scl_in[8], sda_in[9], zero fill
  input  logic [2:0]  s_tuser,   // func[2:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_out, sda_out, ready_res, cmd_done, rx_byte[7:0],
                                 // rx_valid, ack_bit, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  logic              item_valid;
  logic              item_pop;
  logic              res_valid;
  logic              out_full;
  logic              out_empty;
  logic [15:0]       res_bits;

  assign cfg_ready = 1'b1;

  i2cm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .func       (s_tuser),
    .data_byte  (s_tdata[7:0]),
    .last_byte  (s_tlast),
    .scl_in     (s_tdata[8]),
    .sda_in     (s_tdata[9]),
    .pop        (item_pop),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (!out_full),
    .item_pop   (item_pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign res_bits = {2'b00, res.ack_bit, res.rx_valid, res.rx_byte, res.cmd_done,
                     res.ready_res, res.sda_out, res.scl_out};

  i2cm_fifo #(
    .WIDTH (16),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .wr_data (res_bits),
    .pop     (m_tready),
    .rd_data (m_tdata),
    .full    (out_full),
    .empty   (out_empty)
  );

  assign m_tvalid = !out_empty;

endmodule

// File: bench/i2c_master_byte_engine_core_test.sv
// Self-checking stream bench for the I2C master byte engine: cycle-accurate prediction.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core_test;

  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       scl_in;
    logic       sda_in;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  sample_t line_samples[$];
  i2cm_pkg::result_t engine_outputs_exp[$];

  i2cm_pkg::phase_t eng_phase = i2cm_pkg::PH_IDLE;
  logic [2:0]  eng_cmd = i2cm_pkg::CMD_NONE;
  logic [3:0]  eng_bits = '0;
  logic [7:0]  eng_shift = '0;
  logic        eng_nack = 1'b0;
  logic [15:0] eng_timer = '0;
  logic        eng_scl = 1'b1;
  logic        eng_sda = 1'b1;
  logic        eng_ack = 1'b0;
  logic [15:0] eng_half = i2cm_pkg::HALF_PERIOD_RST;

  int mismatches = 0;
  int issued = 0;
  int cycle_count = 0;
  int stretch_pct = 0;
  int sda_mode = 2;
  bit s_fire = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  logic [7:0] stall_pat = 8'hff;

  i2c_master_byte_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic i2cm_pkg::result_t engine_step(input sample_t s);
    i2cm_pkg::result_t r;
    logic        done;
    logic        rxv;
    logic [7:0]  rxb;
    logic [15:0] load;
    load = (eng_half == 16'd0) ? 16'd1 : eng_half;
    done = 1'b0;
    rxv  = 1'b0;
    rxb  = 8'd0;
    if (eng_phase == i2cm_pkg::PH_IDLE) begin
      eng_cmd = s.func;
      case (s.func)
        i2cm_pkg::CMD_START: begin
          eng_sda = 1'b1;
          eng_phase = i2cm_pkg::PH_S_SDA_UP;
          eng_timer = load;
        end
        i2cm_pkg::CMD_WRITE: begin
          eng_shift = s.data_byte;
          eng_bits = 4'd0;
          eng_scl = 1'b0;
          eng_sda = s.data_byte[7];
          eng_phase = i2cm_pkg::PH_BIT_LOW;
          eng_timer = load;
        end
        i2cm_pkg::CMD_READ: begin
          eng_shift = 8'd0;
          eng_bits = 4'd0;
          eng_nack = s.last_byte;
          eng_scl = 1'b0;
          eng_sda = 1'b1;
          eng_phase = i2cm_pkg::PH_BIT_LOW;
          eng_timer = load;
        end
        i2cm_pkg::CMD_STOP: begin
          eng_scl = 1'b0;
          eng_sda = 1'b0;
          eng_phase = i2cm_pkg::PH_P_LOW;
          eng_timer = load;
        end
        default: eng_cmd = i2cm_pkg::CMD_NONE;
      endcase
    end else if ((eng_phase == i2cm_pkg::PH_S_SCL_UP || eng_phase == i2cm_pkg::PH_BIT_HIGH ||
                  eng_phase == i2cm_pkg::PH_P_SCL_UP) && !s.scl_in) begin
      eng_timer = eng_timer;
    end else if (eng_timer > 16'd1) begin
      eng_timer = eng_timer - 16'd1;
    end else begin
      case (eng_phase)
        i2cm_pkg::PH_S_SDA_UP: begin
          eng_scl = 1'b1;
          eng_phase = i2cm_pkg::PH_S_SCL_UP;
          eng_timer = load;
        end
        i2cm_pkg::PH_S_SCL_UP: begin
          eng_sda = 1'b0;
          eng_phase = i2cm_pkg::PH_S_SDA_DN;
          eng_timer = load;
        end
        i2cm_pkg::PH_S_SDA_DN: begin
          eng_scl = 1'b0;
          eng_phase = i2cm_pkg::PH_S_SCL_DN;
          eng_timer = load;
        end
        i2cm_pkg::PH_BIT_LOW: begin
          eng_scl = 1'b1;
          eng_phase = i2cm_pkg::PH_BIT_HIGH;
          eng_timer = load;
        end
        i2cm_pkg::PH_P_LOW: begin
          eng_scl = 1'b1;
          eng_phase = i2cm_pkg::PH_P_SCL_UP;
          eng_timer = load;
        end
        i2cm_pkg::PH_P_SCL_UP: begin
          eng_sda = 1'b1;
          eng_phase = i2cm_pkg::PH_P_SDA_UP;
          eng_timer = load;
        end
        i2cm_pkg::PH_BIT_HIGH: begin
          if (eng_bits < i2cm_pkg::DATA_BITS) begin
            eng_shift = {eng_shift[6:0],
                         (eng_cmd == i2cm_pkg::CMD_READ) ? s.sda_in : 1'b0};
          end else if (eng_cmd == i2cm_pkg::CMD_WRITE) begin
            eng_ack = s.sda_in;
          end
          eng_bits = eng_bits + 4'd1;
          eng_scl = 1'b0;
          if (eng_bits > i2cm_pkg::DATA_BITS) begin
            eng_phase = i2cm_pkg::PH_IDLE;
            eng_timer = 16'd0;
            done = 1'b1;
            if (eng_cmd == i2cm_pkg::CMD_READ) begin
              rxv = 1'b1;
              rxb = eng_shift;
            end
          end else begin
            if (eng_bits == i2cm_pkg::DATA_BITS)
              eng_sda = (eng_cmd == i2cm_pkg::CMD_READ) ? eng_nack : 1'b1;
            else
              eng_sda = (eng_cmd == i2cm_pkg::CMD_READ) ? 1'b1 : eng_shift[7];
            eng_phase = i2cm_pkg::PH_BIT_LOW;
            eng_timer = load;
          end
        end
        default: begin
          eng_phase = i2cm_pkg::PH_IDLE;
          eng_timer = 16'd0;
          done = 1'b1;
        end
      endcase
    end
    r.scl_out   = eng_scl;
    r.sda_out   = eng_sda;
    r.ready_res = (eng_phase == i2cm_pkg::PH_IDLE);
    r.cmd_done  = done;
    r.rx_byte   = rxb;
    r.rx_valid  = rxv;
    r.ack_bit   = eng_ack;
    return r;
  endfunction

  task automatic report_field(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_cycle(input logic [2:0] func, input logic [7:0] data, input logic last);
    sample_t s;
    s.func      = func;
    s.data_byte = data;
    s.last_byte = last;
    s.scl_in    = eng_scl ? ($urandom_range(99) >= stretch_pct) : ($urandom_range(9) == 0);
    s.sda_in    = (sda_mode == 2) ? 1'($urandom_range(1)) : 1'(sda_mode);
    engine_outputs_exp.push_back(engine_step(s));
    line_samples.push_back(s);
    issued++;
  endtask

  task automatic run_command(input logic [2:0] func, input logic [7:0] data, input logic last);
    push_cycle(func, data, last);
    while (eng_phase != i2cm_pkg::PH_IDLE)
      push_cycle(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : i2cm_pkg::CMD_NONE,
                 8'($urandom), 1'($urandom));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n)
      push_cycle(($urandom_range(1) == 0) ? i2cm_pkg::CMD_NONE : 3'($urandom_range(5, 7)),
                 8'($urandom), 1'($urandom));
  endtask

  task automatic run_transfer();
    int ops;
    int i;
    ops = $urandom_range(1, 4);
    if ($urandom_range(4) == 0) begin
      for (i = 0; i < ops + 1; i++) begin
        idle_cycles($urandom_range(0, 2));
        run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
      end
    end else begin
      run_command(i2cm_pkg::CMD_START, 8'd0, 1'b0);
      run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
      for (i = 0; i < ops; i++) begin
        if ($urandom_range(5) == 0) idle_cycles($urandom_range(1, 3));
        if ($urandom_range(7) == 0) begin
          run_command(i2cm_pkg::CMD_START, 8'd0, 1'b0);
          run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
        end
        if ($urandom_range(1) == 0)
          run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
        else
          run_command(i2cm_pkg::CMD_READ, 8'($urandom),
                      (i == ops - 1) ? 1'b1 : 1'($urandom));
      end
      run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    while (line_samples.size() != 0 || engine_outputs_exp.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_half(input logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    eng_half = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(9))
      0, 1, 2: return 16'd1;
      3, 4:    return 16'd2;
      5:       return 16'd3;
      6:       return 16'd4;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("i2c_master_byte_engine_core_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    i2cm_pkg::result_t want;
    s_fire = !rst && s_tvalid && s_tready;
    if (s_fire && line_samples.size() != 0) line_samples.pop_front();
    if (!rst && m_tvalid && m_tready) begin
      if (engine_outputs_exp.size() == 0) begin
        report_field("unexpected result", m_tdata, 0);
      end else begin
        want = engine_outputs_exp.pop_front();
        if (m_tdata[0] !== want.scl_out) report_field("scl_out", m_tdata[0], want.scl_out);
        if (m_tdata[1] !== want.sda_out) report_field("sda_out", m_tdata[1], want.sda_out);
        if (m_tdata[2] !== want.ready_res)
          report_field("ready_res", m_tdata[2], want.ready_res);
        if (m_tdata[3] !== want.cmd_done) report_field("cmd_done", m_tdata[3], want.cmd_done);
        if (m_tdata[11:4] !== want.rx_byte) report_field("rx_byte", m_tdata[11:4], want.rx_byte);
        if (m_tdata[12] !== want.rx_valid) report_field("rx_valid", m_tdata[12], want.rx_valid);
        if (m_tdata[13] !== want.ack_bit) report_field("ack_bit", m_tdata[13], want.ack_bit);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (line_samples.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, line_samples[0].sda_in, line_samples[0].scl_in,
                     line_samples[0].data_byte};
        s_tuser  <= line_samples[0].func;
        s_tlast  <= line_samples[0].last_byte;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(20, 150);
      stall_pat = 8'($urandom);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(9) < 7);
      default: begin
        m_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  initial begin
    int random_start;
    int target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the half period
    run_command(i2cm_pkg::CMD_START, 8'd0, 1'b0);
    idle_cycles(2);

    write_half(16'd0);
    run_command(i2cm_pkg::CMD_START, 8'd0, 1'b0);
    sda_mode = 0;
    run_command(i2cm_pkg::CMD_WRITE, 8'hff, 1'b0);
    sda_mode = 1;
    run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1);
    run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
    sda_mode = 0;
    run_command(i2cm_pkg::CMD_READ, 8'hff, 1'b1);
    sda_mode = 2;
    stretch_pct = 40;
    run_command(i2cm_pkg::CMD_START, 8'd0, 1'b0);
    stretch_pct = 0;
    push_cycle(i2cm_pkg::CMD_READ, 8'h5a, 1'b1);
    push_cycle(i2cm_pkg::CMD_STOP, 8'ha5, 1'b0);
    run_command(3'd7, 8'h3c, 1'b1);
    idle_cycles(3);
    run_command(i2cm_pkg::CMD_STOP, 8'd0, 1'b0);

    write_half(16'hffff);
    idle_cycles(40);

    write_half(16'd1);
    random_start = issued;
    while (issued - random_start < RANDOM_ITEMS) begin
      target = issued + $urandom_range(150, 300);
      case ($urandom_range(2))
        0: stretch_pct = 0;
        1: stretch_pct = 10;
        default: stretch_pct = 35;
      endcase
      while (issued < target && issued - random_start < RANDOM_ITEMS) run_transfer();
      write_half(pick_half());
    end

    write_half(16'hffff);
    idle_cycles(20);

    drain();
    repeat (8) @(negedge clk);
    while (engine_outputs_exp.size() != 0) begin
      report_field("missing result", 0, 1);
      void'(engine_outputs_exp.pop_front());
    end
    if (mismatches == 0)
      $display("i2c_master_byte_engine_core_test: clean");
    else
      $display("i2c_master_byte_engine_core_test: errors");
    $finish;
  end

endmodule
